>>> design/kct_pkg.sv
// ---------------------------------------------------------------------------
// kct_pkg
// shared constants, codes and types of the k-mer count table
// ---------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

  localparam int CAPACITY   = 1024;
  localparam int HIST_DEPTH = 256;
  localparam int COUNT_BITS = 32;

  localparam int CNT_W   = COUNT_BITS;
  localparam int CAP_AW  = $clog2(CAPACITY);
  localparam int HIST_W  = $clog2(HIST_DEPTH);
  localparam int ENT_W   = $clog2(CAPACITY + 1);
  localparam int HCNT_W  = ENT_W;
  localparam int SWEEP_N = (CAPACITY > HIST_DEPTH) ? CAPACITY : HIST_DEPTH;
  localparam int SW_W    = $clog2(SWEEP_N);
  localparam int SUM_W   = HIST_W + HCNT_W;
  localparam int TOT_W   = 48;
  localparam int PROD_W  = TOT_W + 7;
  localparam int CMP_W   = (SUM_W + 8 > PROD_W) ? SUM_W + 8 : PROD_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // command codes
  localparam logic [3:0] CMD_CLEAR  = 4'd0;
  localparam logic [3:0] CMD_ADD    = 4'd1;
  localparam logic [3:0] CMD_QUERY  = 4'd2;
  localparam logic [3:0] CMD_DEC    = 4'd3;
  localparam logic [3:0] CMD_REMOVE = 4'd4;
  localparam logic [3:0] CMD_RUNDER = 4'd5;
  localparam logic [3:0] CMD_DIST   = 4'd6;
  localparam logic [3:0] CMD_THRESH = 4'd7;
  localparam logic [3:0] CMD_MODE   = 4'd8;
  localparam logic [3:0] CMD_MOST   = 4'd9;
  localparam logic [3:0] CMD_LEAST  = 4'd10;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;

  // configuration register indexes
  localparam logic REG_MIN_COUNT  = 1'b0;
  localparam logic REG_MODE_FLOOR = 1'b1;

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_HIST_RD, ST_HIST_WR,
    ST_HCLR, ST_FINISH, ST_THR_RD, ST_THR_ACC, ST_THR_CMP, ST_MODE_RD,
    ST_MODE_CHK, ST_DONE
  } state_t;

  typedef struct packed {
    logic              key_we;
    logic              cnt_we;
    logic [CAP_AW-1:0] addr;
    logic [63:0]       key;
    logic              valid;
    logic [CNT_W-1:0]  cnt;
  } kct_ent_wr_t;

  typedef struct packed {
    logic [63:0]      key;
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } kct_ent_rd_t;

  typedef struct packed {
    logic              we;
    logic [HIST_W-1:0] addr;
    logic [HCNT_W-1:0] data;
  } kct_hist_wr_t;

  // subtraction from the running total that stops at zero
  function automatic logic [TOT_W-1:0] total_sub(input logic [TOT_W-1:0] t,
                                                 input logic [TOT_W-1:0] v);
    total_sub = (t > v) ? t - v : '0;
  endfunction

endpackage

`default_nettype wire

>>> design/kct_store.sv
// ---------------------------------------------------------------------------
// kct_store
// entry memory (key, valid, count) and histogram memory, registered reads
// ---------------------------------------------------------------------------
`default_nettype none

module kct_store import kct_pkg::*; (
  input  wire  logic              clk,
  input  wire  logic [CAP_AW-1:0] rd_addr,
  input  wire  logic [HIST_W-1:0] hist_rd_addr,
  input  wire  kct_ent_wr_t       ent_wr,
  input  wire  kct_hist_wr_t      hist_wr,
  output kct_ent_rd_t             ent_rd,
  output logic [HCNT_W-1:0]       hist_q
);

  logic [63:0]      key_mem  [CAPACITY];
  logic [CNT_W:0]   cnt_mem  [CAPACITY];
  logic [HCNT_W-1:0] hist_mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (ent_wr.key_we) begin
      key_mem[ent_wr.addr] <= ent_wr.key;
    end
    if (ent_wr.cnt_we) begin
      cnt_mem[ent_wr.addr] <= {ent_wr.valid, ent_wr.cnt};
    end
    ent_rd.key                 <= key_mem[rd_addr];
    {ent_rd.valid, ent_rd.cnt} <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (hist_wr.we) begin
      hist_mem[hist_wr.addr] <= hist_wr.data;
    end
    hist_q <= hist_mem[hist_rd_addr];
  end

endmodule

`default_nettype wire

>>> design/kmer_count_table_top.sv
// ---------------------------------------------------------------------------
// kmer_count_table_top
// counting table of 64-bit k-mer codes with count histogram and statistics
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start / busy         in_cmd in_key in_amount in_percent
//  result    out_valid (1 cycle)  out_count out_present out_key_out
//                                 out_max_count out_total out_value
//                                 out_entries out_status
//  config    cfg_we               cfg_index cfg_wdata
//
//  add, query, decrease, remove, remove_under, most and least walk the entry
//  memory through its single read port, a read and a check state an entry;
//  distribution clears the histogram, then walks the entries with a
//  histogram read and write added per held entry; threshold reads,
//  accumulates and compares per bin walked, mode reads and checks per bin
//  clear and the pass after reset write max(CAPACITY, HIST_DEPTH) entries,
//  one a cycle; busy stays high throughout, config writes are still taken
//  the result strobe is not stalled: the receiver must take it
// ---------------------------------------------------------------------------
`default_nettype none

module kmer_count_table_top import kct_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        start,
  output logic              busy,
  input  wire  logic [3:0]  in_cmd,
  input  wire  logic [63:0] in_key,
  input  wire  logic [31:0] in_amount,
  input  wire  logic [6:0]  in_percent,
  output logic              out_valid,
  output logic [31:0]       out_count,
  output logic              out_present,
  output logic [63:0]       out_key_out,
  output logic [31:0]       out_max_count,
  output logic [47:0]       out_total,
  output logic [31:0]       out_value,
  output logic [10:0]       out_entries,
  output logic [1:0]        out_status,
  input  wire  logic        cfg_we,
  input  wire  logic        cfg_index,
  input  wire  logic [31:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // latched transaction
  logic [3:0]  cmd_r, cmd_nxt;
  logic [63:0] key_r, key_nxt;
  logic [31:0] amount_r, amount_nxt;

  // configuration
  logic [31:0] min_count_r;
  logic [7:0]  mode_floor_r;

  // table statistics
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] largest_r, largest_nxt;
  logic [ENT_W-1:0] entries_r, entries_nxt;

  // walk counters
  logic [CAP_AW-1:0] idx_r, idx_nxt;
  logic [SW_W-1:0]   sw_r, sw_nxt;
  logic [HIST_W-1:0] hidx_r, hidx_nxt;
  logic              sweep_cmd_r, sweep_cmd_nxt;

  // scan findings
  logic              found_r, found_nxt;
  logic [CAP_AW-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic              free_r, free_nxt;
  logic [CAP_AW-1:0] fslot_r, fslot_nxt;
  logic [63:0]       bkey_r, bkey_nxt;

  // histogram walks
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [HCNT_W-1:0] best_r, best_nxt;

  // result under construction
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              res_pres_r, res_pres_nxt;
  logic [63:0]       res_kout_r, res_kout_nxt;
  logic [HIST_W-1:0] res_val_r, res_val_nxt;
  logic [1:0]        res_st_r, res_st_nxt;

  // result port registers
  logic out_valid_r, out_valid_nxt;

  kct_ent_wr_t  ent_wr;
  kct_ent_rd_t  ent_rd;
  kct_hist_wr_t hist_wr;
  logic [HCNT_W-1:0] hist_q;

  logic [HIST_W-1:0] top_bin;
  logic [CNT_W-1:0]  new_cnt;
  logic [CMP_W-1:0]  lhs_cmp;
  logic              better;
  logic              advance;

  kct_store u_store (
    .clk          (clk),
    .rd_addr      (idx_r),
    .hist_rd_addr (hidx_r),
    .ent_wr       (ent_wr),
    .hist_wr      (hist_wr),
    .ent_rd       (ent_rd),
    .hist_q       (hist_q)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // highest bin that threshold and mode look at
  assign top_bin = (32'(largest_r) < 32'(HIST_DEPTH - 1)) ? HIST_W'(largest_r)
                                                          : HIST_W'(HIST_DEPTH - 1);
  // 100*(sum+1) > total*percent is the same as sum >= total*percent/100
  assign lhs_cmp = (CMP_W'(sum_r) + CMP_W'(1)) * CMP_W'(100);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_count_r  <= '0;
      mode_floor_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_COUNT:  min_count_r  <= cfg_wdata;
        REG_MODE_FLOOR: mode_floor_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_r        <= '0;
      sweep_cmd_r <= 1'b0;
      total_r     <= '0;
      largest_r   <= '0;
      entries_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      sweep_cmd_r <= sweep_cmd_nxt;
      total_r     <= total_nxt;
      largest_r   <= largest_nxt;
      entries_r   <= entries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    amount_r   <= amount_nxt;
    idx_r      <= idx_nxt;
    hidx_r     <= hidx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    fcnt_r     <= fcnt_nxt;
    free_r     <= free_nxt;
    fslot_r    <= fslot_nxt;
    bkey_r     <= bkey_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    best_r     <= best_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_pres_r <= res_pres_nxt;
    res_kout_r <= res_kout_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
  end

  // result ports, loaded when a transaction finishes
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_count     <= 32'(res_cnt_r);
      out_present   <= res_pres_r;
      out_key_out   <= res_kout_r;
      out_max_count <= 32'(largest_r);
      out_total     <= total_r;
      out_value     <= 32'(res_val_r);
      out_entries   <= 11'(entries_r);
      out_status    <= res_st_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    amount_nxt    = amount_r;
    total_nxt     = total_r;
    largest_nxt   = largest_r;
    entries_nxt   = entries_r;
    idx_nxt       = idx_r;
    sw_nxt        = sw_r;
    hidx_nxt      = hidx_r;
    sweep_cmd_nxt = sweep_cmd_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    fcnt_nxt      = fcnt_r;
    free_nxt      = free_r;
    fslot_nxt     = fslot_r;
    bkey_nxt      = bkey_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    best_nxt      = best_r;
    res_cnt_nxt   = res_cnt_r;
    res_pres_nxt  = res_pres_r;
    res_kout_nxt  = res_kout_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = 1'b0;
    ent_wr        = '0;
    hist_wr       = '0;
    new_cnt       = '0;
    better        = 1'b0;
    advance       = 1'b0;

    unique case (state_r)
      // clearing pass: after reset and for the clear command
      ST_SWEEP: begin
        if (int'(sw_r) < CAPACITY) begin
          ent_wr.cnt_we = 1'b1;
          ent_wr.addr   = CAP_AW'(sw_r);
        end
        if (int'(sw_r) < HIST_DEPTH) begin
          hist_wr.we   = 1'b1;
          hist_wr.addr = HIST_W'(sw_r);
        end
        if (sw_r == SW_W'(SWEEP_N - 1)) begin
          state_nxt = sweep_cmd_r ? ST_DONE : ST_IDLE;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          cmd_nxt      = in_cmd;
          key_nxt      = in_key;
          amount_nxt   = in_amount;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          free_nxt     = 1'b0;
          res_cnt_nxt  = '0;
          res_pres_nxt = 1'b0;
          res_kout_nxt = '0;
          res_val_nxt  = '0;
          res_st_nxt   = STAT_OK;
          case (in_cmd)
            CMD_CLEAR: begin
              sw_nxt        = '0;
              sweep_cmd_nxt = 1'b1;
              entries_nxt   = '0;
              state_nxt     = ST_SWEEP;
            end
            CMD_ADD, CMD_QUERY, CMD_DEC, CMD_REMOVE, CMD_RUNDER, CMD_MOST,
            CMD_LEAST: begin
              state_nxt = ST_SCAN_RD;
            end
            CMD_DIST: begin
              largest_nxt = '0;
              total_nxt   = '0;
              hidx_nxt    = '0;
              state_nxt   = ST_HCLR;
            end
            CMD_THRESH: begin
              prod_nxt = PROD_W'(total_r) * PROD_W'(in_percent);
              sum_nxt  = '0;
              hidx_nxt = top_bin;
              state_nxt = (top_bin == '0) ? ST_DONE : ST_THR_RD;
            end
            CMD_MODE: begin
              best_nxt = '0;
              hidx_nxt = HIST_W'(mode_floor_r);
              state_nxt = (32'(mode_floor_r) > 32'(top_bin)) ? ST_DONE : ST_MODE_RD;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_SCAN_RD: state_nxt = ST_SCAN_CHK;

      ST_SCAN_CHK: begin
        advance = 1'b1;
        case (cmd_r)
          CMD_ADD, CMD_QUERY, CMD_DEC, CMD_REMOVE: begin
            if (ent_rd.valid && ent_rd.key == key_r && !found_r) begin
              found_nxt = 1'b1;
              slot_nxt  = idx_r;
              fcnt_nxt  = ent_rd.cnt;
            end
            if (!ent_rd.valid && !free_r) begin
              free_nxt  = 1'b1;
              fslot_nxt = idx_r;
            end
          end
          CMD_RUNDER: begin
            if (ent_rd.valid && 32'(ent_rd.cnt) < amount_r) begin
              ent_wr.cnt_we = 1'b1;
              ent_wr.addr   = idx_r;
              total_nxt     = total_sub(total_r, TOT_W'(ent_rd.cnt));
              if (entries_r != '0) begin
                entries_nxt = entries_r - 1'b1;
              end
            end
          end
          CMD_MOST, CMD_LEAST: begin
            if (ent_rd.key < bkey_r) begin
              better = (ent_rd.cnt == fcnt_r);
            end
            if (ent_rd.cnt != fcnt_r) begin
              better = (cmd_r == CMD_MOST) ? (ent_rd.cnt > fcnt_r)
                                           : (ent_rd.cnt < fcnt_r);
            end
            if (ent_rd.valid && (!found_r || better)) begin
              found_nxt = 1'b1;
              fcnt_nxt  = ent_rd.cnt;
              bkey_nxt  = ent_rd.key;
            end
          end
          CMD_DIST: begin
            if (ent_rd.valid) begin
              advance = 1'b0;
              if (ent_rd.cnt > largest_r) begin
                largest_nxt = ent_rd.cnt;
              end
              total_nxt = total_r + TOT_W'(ent_rd.cnt);
              hidx_nxt  = (32'(ent_rd.cnt) < 32'(HIST_DEPTH - 1))
                          ? HIST_W'(ent_rd.cnt) : HIST_W'(HIST_DEPTH - 1);
              state_nxt = ST_HIST_RD;
            end
          end
          default: ;
        endcase
      end

      ST_HIST_RD: state_nxt = ST_HIST_WR;

      ST_HIST_WR: begin
        hist_wr.we   = 1'b1;
        hist_wr.addr = hidx_r;
        hist_wr.data = hist_q + 1'b1;
        advance      = 1'b1;
      end

      ST_HCLR: begin
        hist_wr.we   = 1'b1;
        hist_wr.addr = hidx_r;
        if (hidx_r == HIST_W'(HIST_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_SCAN_RD;
        end else begin
          hidx_nxt = hidx_r + 1'b1;
        end
      end

      ST_FINISH: begin
        state_nxt = ST_DONE;
        case (cmd_r)
          CMD_ADD: begin
            if (found_r) begin
              new_cnt       = (fcnt_r == COUNT_MAX) ? fcnt_r : fcnt_r + 1'b1;
              ent_wr.cnt_we = 1'b1;
              ent_wr.addr   = slot_r;
              ent_wr.valid  = 1'b1;
              ent_wr.cnt    = new_cnt;
              res_cnt_nxt   = new_cnt;
              res_pres_nxt  = 1'b1;
            end else if (free_r) begin
              ent_wr.key_we = 1'b1;
              ent_wr.cnt_we = 1'b1;
              ent_wr.addr   = fslot_r;
              ent_wr.key    = key_r;
              ent_wr.valid  = 1'b1;
              ent_wr.cnt    = CNT_W'(1);
              entries_nxt   = entries_r + 1'b1;
              res_cnt_nxt   = CNT_W'(1);
              res_pres_nxt  = 1'b1;
            end else begin
              res_st_nxt = STAT_FULL;
            end
          end
          CMD_QUERY: begin
            if (found_r) begin
              res_cnt_nxt  = fcnt_r;
              res_pres_nxt = 1'b1;
            end else begin
              res_st_nxt = STAT_ABSENT;
            end
          end
          CMD_DEC, CMD_REMOVE: begin
            if (!found_r) begin
              res_st_nxt = STAT_ABSENT;
            end else if (cmd_r == CMD_REMOVE ||
                         33'(fcnt_r) <= 33'(amount_r) + 33'(min_count_r)) begin
              // erase the entry
              ent_wr.cnt_we = 1'b1;
              ent_wr.addr   = slot_r;
              total_nxt     = total_sub(total_r, TOT_W'(fcnt_r));
              if (entries_r != '0) begin
                entries_nxt = entries_r - 1'b1;
              end
            end else begin
              new_cnt       = fcnt_r - CNT_W'(amount_r);
              total_nxt     = total_sub(total_r, TOT_W'(amount_r));
              ent_wr.cnt_we = 1'b1;
              ent_wr.addr   = slot_r;
              ent_wr.valid  = 1'b1;
              ent_wr.cnt    = new_cnt;
              res_cnt_nxt   = new_cnt;
              res_pres_nxt  = 1'b1;
            end
          end
          CMD_MOST, CMD_LEAST: begin
            if (found_r) begin
              res_kout_nxt = bkey_r;
              res_cnt_nxt  = fcnt_r;
              res_pres_nxt = 1'b1;
            end else begin
              res_st_nxt = STAT_ABSENT;
            end
          end
          default: ;
        endcase
      end

      ST_THR_RD: state_nxt = ST_THR_ACC;

      ST_THR_ACC: begin
        sum_nxt   = sum_r + SUM_W'(hidx_r) * SUM_W'(hist_q);
        state_nxt = ST_THR_CMP;
      end

      ST_THR_CMP: begin
        if (lhs_cmp > CMP_W'(prod_r)) begin
          res_val_nxt = hidx_r;
          state_nxt   = ST_DONE;
        end else if (hidx_r == HIST_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          hidx_nxt  = hidx_r - 1'b1;
          state_nxt = ST_THR_RD;
        end
      end

      ST_MODE_RD: state_nxt = ST_MODE_CHK;

      ST_MODE_CHK: begin
        if (hist_q > best_r) begin
          best_nxt    = hist_q;
          res_val_nxt = hidx_r;
        end
        if (hidx_r == top_bin) begin
          state_nxt = ST_DONE;
        end else begin
          hidx_nxt  = hidx_r + 1'b1;
          state_nxt = ST_MODE_RD;
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // step to the next entry or close the scan
    if (advance) begin
      if (idx_r == CAP_AW'(CAPACITY - 1)) begin
        state_nxt = ST_FINISH;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_SCAN_RD;
      end
    end
  end

  // a result strobe only follows the end of a transaction
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_IDLE)
    else $error("result strobe outside idle");

  a_entries_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(entries_r) <= 32'(CAPACITY))
    else $error("entry count beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction left block idle");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (!out_present && out_count == 32'd0))
    else $error("full table result carries a count");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> state_r == ST_SWEEP)
    else $error("no clearing pass after reset");

endmodule

`default_nettype wire
